// File: rtl/hrhp_pkg.sv
// Shared constants, types and literal tables for the HTTP request header parser.
`default_nettype none

package hrhp_pkg;

    localparam int MAX_REQUEST_BYTES_DEF = 4096;
    localparam int CAP_W                 = 13;
    localparam int FIELD_W               = 12;
    localparam logic [CAP_W-1:0] URL_CAP_RST  = 13'd256;
    localparam logic [CAP_W-1:0] HOST_CAP_RST = 13'd64;

    // register indexes
    localparam logic CFG_URL_CAP  = 1'b0;
    localparam logic CFG_HOST_CAP = 1'b1;

    // event codes
    localparam logic [3:0] EV_REQ_OK      = 4'd0;
    localparam logic [3:0] EV_HEADER      = 4'd1;
    localparam logic [3:0] EV_END_HDRS    = 4'd2;
    localparam logic [3:0] EV_BAD_METHOD  = 4'd3;
    localparam logic [3:0] EV_BAD_VERSION = 4'd4;
    localparam logic [3:0] EV_EXTRA_CHARS = 4'd5;
    localparam logic [3:0] EV_BAD_HEADER  = 4'd6;
    localparam logic [3:0] EV_URL_LONG    = 4'd7;
    localparam logic [3:0] EV_HOST_LONG   = 4'd8;
    localparam logic [3:0] EV_REQ_LONG    = 4'd9;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;

    localparam logic [2:0] GET_LEN  = 3'd4;
    localparam logic [2:0] POST_LEN = 3'd5;
    localparam logic [2:0] HTTP_LEN = 3'd5;
    localparam logic [2:0] HOST_LEN = 3'd4;
    localparam logic [2:0] KEY_SAT  = 3'd5;

    typedef struct packed {
        logic [3:0]         event_res;
        logic               method;
        logic [FIELD_W-1:0] url_offset;
        logic [FIELD_W-1:0] url_length;
        logic [FIELD_W-1:0] value_offset;
        logic [FIELD_W-1:0] value_length;
        logic               is_host;
        logic [FIELD_W-1:0] body_offset;
    } result_t;

    typedef struct packed {
        logic [2:0] len;
        logic       still_host;
    } key_t;

    function automatic logic [7:0] get_char(input logic [2:0] idx);
        case (idx)
            3'd0:    get_char = 8'h47; // G
            3'd1:    get_char = 8'h45; // E
            3'd2:    get_char = 8'h54; // T
            3'd3:    get_char = 8'h20;
            default: get_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] post_char(input logic [2:0] idx);
        case (idx)
            3'd0:    post_char = 8'h50; // P
            3'd1:    post_char = 8'h4F; // O
            3'd2:    post_char = 8'h53; // S
            3'd3:    post_char = 8'h54; // T
            3'd4:    post_char = 8'h20;
            default: post_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] http_char(input logic [2:0] idx);
        case (idx)
            3'd0:    http_char = 8'h48; // H
            3'd1:    http_char = 8'h54; // T
            3'd2:    http_char = 8'h54; // T
            3'd3:    http_char = 8'h50; // P
            3'd4:    http_char = 8'h2F; // /
            default: http_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] host_char(input logic [2:0] idx);
        case (idx)
            3'd0:    host_char = 8'h48; // H
            3'd1:    host_char = 8'h6F; // o
            3'd2:    host_char = 8'h73; // s
            3'd3:    host_char = 8'h74; // t
            default: host_char = 8'h00;
        endcase
    endfunction

    // one more key byte: length saturates, since only "four" and "more than four" matter
    function automatic key_t key_step(input key_t k, input logic [7:0] b);
        key_t r;
        r = k;
        if (k.len >= HOST_LEN || b != host_char(k.len)) begin
            r.still_host = 1'b0;
        end
        if (k.len != KEY_SAT) begin
            r.len = k.len + 3'd1;
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

// File: rtl/http_request_header_parser.sv
// HTTP request header parser: one request byte per cycle while s_tready is high, one event per completed line or error.
//
// Input channel s_*: one request byte per item; s_tuser set on the first byte of a
// request clears the parser and makes that byte position 0. Bytes arriving while
// idle (after an error or the end of headers) with s_tuser low are dropped.
// Output channel m_*: one event item per completed request line, header line,
// end of headers or error; m_tuser carries the event code.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write the URL and Host capacity
// registers; write only while the block is idle.
// Throughput: one byte per cycle while s_tready is high. The parser state machine
// updates in the same cycle the byte is taken, and an event is registered into the
// output register, or into the skid register while the output register is held.
// A two-entry output stage (output register plus skid register) keeps s_tready
// high while one event waits; s_tready drops only when both are full, i.e. after
// m_tready has been low for two events.
// Reset (aresetn low, synchronous): parser idle, capacities 256 and 64, output
// stage empty.
`default_nettype none

module http_request_header_parser
    import hrhp_pkg::*;
#(
    parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] data_byte
    input  wire logic              s_tuser,   // [0] first_byte
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [0] method, [12:1] url_offset, [24:13] url_length, [36:25] value_offset,
    // [48:37] value_length, [49] is_host, [61:50] body_offset, [63:62] zero
    output logic [63:0]            m_tdata,
    output logic [3:0]             m_tuser,   // [3:0] event_res
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_addr,
    input  wire logic [CAP_W-1:0]  cfg_wdata
);

    localparam int PW = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int CW = (PW > CAP_W) ? PW : CAP_W;
    localparam int OW = (PW > FIELD_W) ? PW : FIELD_W;
    localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_REQUEST_BYTES);

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_METHOD  = 5'd1;
    localparam logic [4:0] PH_SKIP1   = 5'd2;
    localparam logic [4:0] PH_URL     = 5'd3;
    localparam logic [4:0] PH_URL_CR  = 5'd4;
    localparam logic [4:0] PH_SKIP2   = 5'd5;
    localparam logic [4:0] PH_VLIT    = 5'd6;
    localparam logic [4:0] PH_VMAJ    = 5'd7;
    localparam logic [4:0] PH_VDOT    = 5'd8;
    localparam logic [4:0] PH_VMIN    = 5'd9;
    localparam logic [4:0] PH_VTAIL   = 5'd10;
    localparam logic [4:0] PH_REQ_CR  = 5'd11;
    localparam logic [4:0] PH_HSTART  = 5'd12;
    localparam logic [4:0] PH_HCR     = 5'd13;
    localparam logic [4:0] PH_KEY     = 5'd14;
    localparam logic [4:0] PH_KEY_CR  = 5'd15;
    localparam logic [4:0] PH_HSKIP   = 5'd16;
    localparam logic [4:0] PH_VAL     = 5'd17;
    localparam logic [4:0] PH_VAL_CR  = 5'd18;

    logic [CAP_W-1:0] url_cap_reg, host_cap_reg;

    logic [4:0]    phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [2:0]    lit_idx_reg, lit_idx_next;
    logic [PW-1:0] url_start_reg, url_start_next;
    logic [PW-1:0] url_end_reg, url_end_next;
    logic [PW-1:0] val_start_reg, val_start_next;
    key_t          key_reg, key_next;
    logic          post_reg, post_next;

    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;
    logic    res_valid;
    logic    s_fire;

    // working copies: a first byte sees the cleared state
    logic [4:0]    cur_phase;
    logic [PW-1:0] cur_pos, cur_url_start, cur_url_end, cur_val_start;
    logic [2:0]    cur_lit;
    key_t          cur_key;
    logic          cur_post;

    logic [PW-1:0] url_len, val_len, body_pos;
    logic [7:0]    b;
    logic [7:0]    meth_char;
    logic [2:0]    meth_len;
    logic          host_hit;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = ~skid_valid_reg;
    assign b        = s_tdata;

    always_comb begin
        if (s_tuser) begin
            cur_phase     = PH_METHOD;
            cur_pos       = '0;
            cur_lit       = 3'd0;
            cur_url_start = '0;
            cur_url_end   = '0;
            cur_val_start = '0;
            cur_key       = '{len: 3'd0, still_host: 1'b1};
            cur_post      = 1'b0;
        end else begin
            cur_phase     = phase_reg;
            cur_pos       = pos_reg;
            cur_lit       = lit_idx_reg;
            cur_url_start = url_start_reg;
            cur_url_end   = url_end_reg;
            cur_val_start = val_start_reg;
            cur_key       = key_reg;
            cur_post      = post_reg;
        end
    end

    assign url_len   = cur_url_end - cur_url_start;
    assign val_len   = cur_pos - PW'(1) - cur_val_start;
    assign body_pos  = cur_pos + PW'(1);
    assign meth_char = cur_post ? post_char(cur_lit) : get_char(cur_lit);
    assign meth_len  = cur_post ? POST_LEN : GET_LEN;
    assign host_hit  = cur_key.still_host && (cur_key.len == HOST_LEN);

    always_comb begin
        logic [3:0]    ev;
        logic [PW-1:0] vo, vl, body;
        logic          host;

        phase_next     = cur_phase;
        pos_next       = cur_pos;
        lit_idx_next   = cur_lit;
        url_start_next = cur_url_start;
        url_end_next   = cur_url_end;
        val_start_next = cur_val_start;
        key_next       = cur_key;
        post_next      = cur_post;
        res_valid      = 1'b0;
        ev             = EV_REQ_OK;
        vo             = '0;
        vl             = '0;
        body           = '0;
        host           = 1'b0;

        if (cur_phase != PH_IDLE) begin
            if (cur_pos >= POS_LIMIT) begin
                res_valid  = 1'b1;
                ev         = EV_REQ_LONG;
                phase_next = PH_IDLE;
            end else begin
                pos_next = cur_pos + PW'(1);
                case (cur_phase)
                    PH_METHOD: begin
                        if (cur_lit == 3'd0) begin
                            if (b == CH_P || b == CH_G) begin
                                post_next    = (b == CH_P);
                                lit_idx_next = 3'd1;
                            end else begin
                                res_valid  = 1'b1;
                                ev         = EV_BAD_METHOD;
                                phase_next = PH_IDLE;
                            end
                        end else if (b != meth_char) begin
                            res_valid  = 1'b1;
                            ev         = EV_BAD_METHOD;
                            phase_next = PH_IDLE;
                        end else begin
                            lit_idx_next = cur_lit + 3'd1;
                            if (cur_lit + 3'd1 == meth_len) begin
                                phase_next = PH_SKIP1;
                            end
                        end
                    end
                    PH_SKIP1: begin
                        if (b != CH_SP) begin
                            url_start_next = cur_pos;
                            url_end_next   = cur_pos;
                            phase_next     = (b == CH_CR) ? PH_URL_CR : PH_URL;
                        end
                    end
                    PH_URL, PH_URL_CR: begin
                        if (cur_phase == PH_URL_CR && b == CH_LF) begin
                            res_valid  = 1'b1;
                            ev         = EV_BAD_VERSION;
                            phase_next = PH_IDLE;
                        end else if (b == CH_SP) begin
                            url_end_next = cur_pos;
                            phase_next   = PH_SKIP2;
                        end else begin
                            phase_next = (b == CH_CR) ? PH_URL_CR : PH_URL;
                        end
                    end
                    PH_SKIP2: begin
                        if (b != CH_SP) begin
                            if (b != http_char(3'd0)) begin
                                res_valid  = 1'b1;
                                ev         = EV_BAD_VERSION;
                                phase_next = PH_IDLE;
                            end else begin
                                lit_idx_next = 3'd1;
                                phase_next   = PH_VLIT;
                            end
                        end
                    end
                    PH_VLIT: begin
                        if (b != http_char(cur_lit)) begin
                            res_valid  = 1'b1;
                            ev         = EV_BAD_VERSION;
                            phase_next = PH_IDLE;
                        end else begin
                            lit_idx_next = cur_lit + 3'd1;
                            if (cur_lit + 3'd1 == HTTP_LEN) begin
                                phase_next = PH_VMAJ;
                            end
                        end
                    end
                    PH_VMAJ, PH_VMIN: begin
                        if (!is_digit(b)) begin
                            res_valid  = 1'b1;
                            ev         = EV_BAD_VERSION;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = (cur_phase == PH_VMAJ) ? PH_VDOT : PH_VTAIL;
                        end
                    end
                    PH_VDOT: begin
                        if (b != CH_DOT) begin
                            res_valid  = 1'b1;
                            ev         = EV_BAD_VERSION;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_VMIN;
                        end
                    end
                    PH_VTAIL: begin
                        if (b == CH_CR) begin
                            phase_next = PH_REQ_CR;
                        end else if (b != CH_SP) begin
                            res_valid  = 1'b1;
                            ev         = EV_EXTRA_CHARS;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_REQ_CR: begin
                        res_valid = 1'b1;
                        if (b != CH_LF) begin
                            ev         = EV_EXTRA_CHARS;
                            phase_next = PH_IDLE;
                        end else if (CW'(url_len) >= CW'(url_cap_reg)) begin
                            ev         = EV_URL_LONG;
                            phase_next = PH_IDLE;
                        end else begin
                            ev         = EV_REQ_OK;
                            phase_next = PH_HSTART;
                            key_next   = '{len: 3'd0, still_host: 1'b1};
                        end
                    end
                    PH_HSTART: begin
                        if (b == CH_CR) begin
                            phase_next = PH_HCR;
                        end else if (b == CH_COLON) begin
                            phase_next = PH_HSKIP;
                        end else if (b != CH_SP) begin
                            key_next   = key_step(cur_key, b);
                            phase_next = PH_KEY;
                        end
                    end
                    PH_HCR, PH_KEY_CR: begin
                        if (b == CH_LF) begin
                            res_valid  = 1'b1;
                            phase_next = PH_IDLE;
                            if (cur_phase == PH_HCR) begin
                                ev   = EV_END_HDRS;
                                body = body_pos;
                            end else begin
                                ev = EV_BAD_HEADER;
                            end
                        end else if (b == CH_COLON) begin
                            // a lone CR opening the line still counts as a key byte
                            if (cur_phase == PH_HCR) begin
                                key_next = '{len: 3'd1, still_host: 1'b0};
                            end
                            phase_next = PH_HSKIP;
                        end else begin
                            if (cur_phase == PH_HCR) begin
                                key_next = key_step('{len: 3'd1, still_host: 1'b0}, b);
                            end else begin
                                key_next = key_step(cur_key, b);
                            end
                            phase_next = (b == CH_CR) ? PH_KEY_CR : PH_KEY;
                        end
                    end
                    PH_KEY: begin
                        if (b == CH_COLON) begin
                            phase_next = PH_HSKIP;
                        end else begin
                            key_next = key_step(cur_key, b);
                            if (b == CH_CR) begin
                                phase_next = PH_KEY_CR;
                            end
                        end
                    end
                    PH_HSKIP: begin
                        if (b != CH_SP) begin
                            val_start_next = cur_pos;
                            phase_next     = (b == CH_CR) ? PH_VAL_CR : PH_VAL;
                        end
                    end
                    PH_VAL, PH_VAL_CR: begin
                        if (cur_phase == PH_VAL_CR && b == CH_LF) begin
                            res_valid = 1'b1;
                            vo        = cur_val_start;
                            vl        = val_len;
                            host      = host_hit;
                            key_next  = '{len: 3'd0, still_host: 1'b1};
                            if (host_hit && CW'(val_len) >= CW'(host_cap_reg)) begin
                                ev         = EV_HOST_LONG;
                                phase_next = PH_IDLE;
                            end else begin
                                ev         = EV_HEADER;
                                phase_next = PH_HSTART;
                            end
                        end else begin
                            phase_next = (b == CH_CR) ? PH_VAL_CR : PH_VAL;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        res.event_res    = ev;
        res.method       = (ev == EV_BAD_METHOD) ? 1'b0 : post_next;
        res.url_offset   = FIELD_W'(OW'(cur_url_start));
        res.url_length   = FIELD_W'(OW'(url_len));
        res.value_offset = FIELD_W'(OW'(vo));
        res.value_length = FIELD_W'(OW'(vl));
        res.is_host      = host;
        res.body_offset  = FIELD_W'(OW'(body));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            url_cap_reg  <= URL_CAP_RST;
            host_cap_reg <= HOST_CAP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_URL_CAP:  url_cap_reg  <= cfg_wdata;
                CFG_HOST_CAP: host_cap_reg <= cfg_wdata;
                default:      url_cap_reg  <= url_cap_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            lit_idx_reg   <= 3'd0;
            url_start_reg <= '0;
            url_end_reg   <= '0;
            val_start_reg <= '0;
            key_reg       <= '{len: 3'd0, still_host: 1'b1};
            post_reg      <= 1'b0;
        end else if (s_fire) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            lit_idx_reg   <= lit_idx_next;
            url_start_reg <= url_start_next;
            url_end_reg   <= url_end_next;
            val_start_reg <= val_start_next;
            key_reg       <= key_next;
            post_reg      <= post_next;
        end
    end

    // output register with a skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_fire && res_valid;
            end
        end else if (s_fire && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (s_fire && res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {2'b00, out_reg.body_offset, out_reg.is_host, out_reg.value_length,
                       out_reg.value_offset, out_reg.url_length, out_reg.url_offset,
                       out_reg.method};

endmodule

`default_nettype wire
